>>> hw/rtl/descriptor_free_list_allocator_defines.svh
// assertion macros used by the checker file
`ifndef DESCRIPTOR_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define DESCRIPTOR_FREE_LIST_ALLOCATOR_DEFINES_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define DFLA_AST_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DFLA_AST_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/dfla_pkg.sv
`timescale 1ns / 1ps
package dfla_pkg;

	localparam int ADDR_W    = 48;
	localparam int STRIDE_W  = 13;
	localparam int CNT_W     = 11;
	localparam int IDX_OUT_W = 10;
	localparam int FREE_W    = 11;
	localparam int FUNC_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_SLOTS = 1024;
	localparam int RST_DEPTH_CAP = 1024;
	localparam logic [ADDR_W-1:0]   RST_BASE   = '0;
	localparam logic [STRIDE_W-1:0] RST_STRIDE = 13'd32;
	localparam logic [CNT_W-1:0]    RST_COUNT  = 11'd1024;

	// operations
	localparam logic [FUNC_W-1:0] FUNC_ALLOC  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_FREE   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_REINIT = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BASE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STRIDE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd2;

	// stream packing
	localparam int IN_W         = FUNC_W + ADDR_W;
	localparam int IN_TDATA_W   = ((IN_W + 7) / 8) * 8;
	localparam int OUT_ADDR_LSB = STATUS_W;
	localparam int OUT_IDX_LSB  = OUT_ADDR_LSB + ADDR_W;
	localparam int OUT_FREE_LSB = OUT_IDX_LSB + IDX_OUT_W;
	localparam int OUT_W        = OUT_FREE_LSB + FREE_W;
	localparam int OUT_TDATA_W  = ((OUT_W + 7) / 8) * 8;

endpackage

>>> hw/rtl/descriptor_free_list_allocator.sv
`timescale 1ns / 1ps
// LIFO slot allocator. Requests arrive on the s_ stream (func, free_address);
// each request gives exactly one result beat on the m_ stream (status,
// slot_address, slot_index, free_slots). Registers base_address, slot_stride
// and slot_count are written through cfg_valid/cfg_index/cfg_data, always
// ready; write them only while no request is in flight.
// One request at a time: s_tready is high only while the sequencer is idle.
// Steps from the accepting edge to m_tvalid, with W = log2(MAX_SLOTS) and
// Q = bits of the largest slot count (10 and 11 by default):
//   allocate: stack read, W shift-add steps of the adder;
//   free: subtract, range check, Q restoring divide steps, push;
//   reinitialize, empty pop, zero stride, unused code: straight to the result.
// The multiply, subtract, range check and divide steps share one adder.
// The result register decouples the sides: the next request is taken while
// a result waits; if the receiver stalls, the following result holds in the
// sequencer until the register frees. After reset the stack holds 0..N-1
// at once, with no clearing pass: a low-water mark of the stack depth tells
// which entries still hold their refill value, so reinitialize needs no pass.
module descriptor_free_list_allocator import dfla_pkg::*; #(
	parameter int MAX_SLOTS = DEF_MAX_SLOTS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // func, free_address
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // status, slot_address, slot_index, free_slots
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [ADDR_W-1:0]      cfg_data
);

	localparam int IDX_W     = $clog2(MAX_SLOTS);
	localparam int DEPTH_W   = $clog2(MAX_SLOTS + 1);
	localparam int CNT_LIM   = (1 << CNT_W) - 1;
	localparam int CNT_MAX   = (MAX_SLOTS < CNT_LIM) ? MAX_SLOTS : CNT_LIM;
	localparam int Q_W       = $clog2(CNT_MAX + 1);
	localparam int C_W       = (DEPTH_W > CNT_W) ? DEPTH_W : CNT_W;
	localparam int RST_DEPTH = (MAX_SLOTS < RST_DEPTH_CAP) ? MAX_SLOTS : RST_DEPTH_CAP;
	localparam int N_MAX     = (IDX_W > Q_W) ? IDX_W : Q_W;
	localparam int STEP_W    = $clog2(N_MAX);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_POP  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_SUB  = 3'd3;
	localparam logic [2:0] ST_CHK  = 3'd4;
	localparam logic [2:0] ST_DIV  = 3'd5;
	localparam logic [2:0] ST_FEND = 3'd6;
	localparam logic [2:0] ST_FIN  = 3'd7;

	logic [2:0]           state_q;
	logic [ADDR_W-1:0]    base_q;
	logic [STRIDE_W-1:0]  stride_q;
	logic [CNT_W-1:0]     count_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [DEPTH_W-1:0]   depth_q;
	logic [DEPTH_W-1:0]   mind_q;
	logic [ADDR_W-1:0]    acc_q;
	logic [ADDR_W-1:0]    mop_q;
	logic [IDX_W-1:0]     mulc_q;
	logic [STRIDE_W-1:0]  rem_q;
	logic [Q_W-1:0]       quo_q;
	logic [STEP_W-1:0]    step_q;
	logic [STATUS_W-1:0]  res_status_q;
	logic [ADDR_W-1:0]    res_addr_q;
	logic [IDX_W-1:0]     res_idx_q;
	logic                 m_valid_q;
	logic [STATUS_W-1:0]  out_status_q;
	logic [ADDR_W-1:0]    out_addr_q;
	logic [IDX_OUT_W-1:0] out_idx_q;
	logic [FREE_W-1:0]    out_free_q;

	logic [FUNC_W-1:0]  in_func;
	logic [ADDR_W-1:0]  in_addr;
	logic [C_W-1:0]     cnt_ext;
	logic [C_W-1:0]     eff_cnt;
	logic [C_W-1:0]     depth_ext;
	logic [DEPTH_W-1:0] pos;
	logic [IDX_W-1:0]   idx_sel;
	logic [IDX_W-1:0]   ram_rdata;
	logic               ram_we;
	logic               out_free;
	logic [ADDR_W-1:0]  add_a;
	logic [ADDR_W-1:0]  add_b;
	logic               add_ci;
	logic [ADDR_W:0]    sum;
	logic               carry;

	assign in_func = s_tdata[FUNC_W-1:0];
	assign in_addr = s_tdata[FUNC_W +: ADDR_W];

	assign cnt_ext   = C_W'(count_q);
	assign eff_cnt   = (cnt_ext > C_W'(MAX_SLOTS)) ? C_W'(MAX_SLOTS) : cnt_ext;
	assign depth_ext = C_W'(depth_q);
	assign pos       = depth_q - DEPTH_W'(1);
	// entries below the low-water mark were not written since the last refill
	assign idx_sel   = (pos < mind_q) ? pos[IDX_W-1:0] : ram_rdata;

	assign ram_we = (state_q == ST_FEND) && (C_W'(quo_q) < eff_cnt) && (depth_ext < eff_cnt);

	dfla_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_SLOTS)
	) u_stack (
		.clk  (clk),
		.we   (ram_we),
		.waddr(depth_q[IDX_W-1:0]),
		.wdata(IDX_W'(quo_q)),
		.raddr(pos[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// shared adder
	always_comb begin
		case (state_q)
			ST_MUL: begin
				add_a  = acc_q;
				add_b  = mulc_q[0] ? mop_q : '0;
				add_ci = 1'b0;
			end
			ST_SUB: begin
				add_a  = addr_q;
				add_b  = ~base_q;
				add_ci = 1'b1;
			end
			ST_CHK: begin
				add_a  = acc_q >> Q_W;
				add_b  = ~ADDR_W'(stride_q);
				add_ci = 1'b1;
			end
			ST_DIV: begin
				add_a  = ADDR_W'({rem_q, acc_q[ADDR_W-1]});
				add_b  = ~ADDR_W'(stride_q);
				add_ci = 1'b1;
			end
			default: begin
				add_a  = '0;
				add_b  = '0;
				add_ci = 1'b0;
			end
		endcase
	end

	assign sum   = {1'b0, add_a} + {1'b0, add_b} + (ADDR_W + 1)'(add_ci);
	assign carry = sum[ADDR_W];

	assign out_free  = !m_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = OUT_TDATA_W'({out_free_q, out_idx_q, out_addr_q, out_status_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			base_q    <= RST_BASE;
			stride_q  <= RST_STRIDE;
			count_q   <= RST_COUNT;
			depth_q   <= DEPTH_W'(RST_DEPTH);
			mind_q    <= DEPTH_W'(RST_DEPTH);
			m_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_BASE:   base_q   <= cfg_data;
					REG_STRIDE: stride_q <= cfg_data[STRIDE_W-1:0];
					REG_COUNT:  count_q  <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end

			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						addr_q       <= in_addr;
						res_status_q <= STAT_OK;
						res_addr_q   <= '0;
						res_idx_q    <= '0;
						case (in_func)
							FUNC_ALLOC: begin
								if (depth_q == '0) begin
									res_status_q <= STAT_EMPTY;
									state_q      <= ST_FIN;
								end else begin
									state_q <= ST_POP;
								end
							end
							FUNC_FREE: begin
								if (stride_q == '0) begin
									res_status_q <= STAT_RANGE;
									state_q      <= ST_FIN;
								end else begin
									state_q <= ST_SUB;
								end
							end
							FUNC_REINIT: begin
								depth_q <= DEPTH_W'(eff_cnt);
								mind_q  <= DEPTH_W'(eff_cnt);
								state_q <= ST_FIN;
							end
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_POP: begin
					res_idx_q <= idx_sel;
					mulc_q    <= idx_sel;
					acc_q     <= base_q;
					mop_q     <= ADDR_W'(stride_q);
					depth_q   <= pos;
					if (pos < mind_q) begin
						mind_q <= pos;
					end
					step_q  <= STEP_W'(IDX_W - 1);
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					acc_q  <= sum[ADDR_W-1:0];
					mop_q  <= mop_q << 1;
					mulc_q <= mulc_q >> 1;
					if (step_q == '0) begin
						res_addr_q <= sum[ADDR_W-1:0];
						state_q    <= ST_FIN;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_SUB: begin
					// no carry means the address lies below the heap
					if (!carry) begin
						res_status_q <= STAT_RANGE;
						state_q      <= ST_FIN;
					end else begin
						acc_q   <= sum[ADDR_W-1:0];
						state_q <= ST_CHK;
					end
				end
				ST_CHK: begin
					// high part at or above the stride: quotient overflows the count range
					if (carry) begin
						res_status_q <= STAT_RANGE;
						state_q      <= ST_FIN;
					end else begin
						rem_q   <= STRIDE_W'(acc_q >> Q_W);
						acc_q   <= acc_q << (ADDR_W - Q_W);
						quo_q   <= '0;
						step_q  <= STEP_W'(Q_W - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (carry) begin
						rem_q <= sum[STRIDE_W-1:0];
					end else begin
						rem_q <= {rem_q[STRIDE_W-2:0], acc_q[ADDR_W-1]};
					end
					quo_q <= {quo_q[Q_W-2:0], carry};
					acc_q <= acc_q << 1;
					if (step_q == '0) begin
						state_q <= ST_FEND;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_FEND: begin
					if (C_W'(quo_q) >= eff_cnt) begin
						res_status_q <= STAT_RANGE;
					end else if (depth_ext >= eff_cnt) begin
						res_status_q <= STAT_FULL;
					end else begin
						depth_q   <= depth_q + DEPTH_W'(1);
						res_idx_q <= IDX_W'(quo_q);
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						out_status_q <= res_status_q;
						out_addr_q   <= res_addr_q;
						out_idx_q    <= IDX_OUT_W'(res_idx_q);
						out_free_q   <= FREE_W'(depth_q);
						m_valid_q    <= 1'b1;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/dfla_ram.sv
`timescale 1ns / 1ps
module dfla_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/dfla_checker.sv
`timescale 1ns / 1ps
`include "descriptor_free_list_allocator_defines.svh"
module dfla_checker import dfla_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic [IN_TDATA_W-1:0]  s_tdata,   // func, free_address
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,   // status, slot_address, slot_index, free_slots
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic [CFG_IDX_W-1:0]   cfg_index,
	input logic [ADDR_W-1:0]      cfg_data
);

	logic [STATUS_W-1:0] st;
	logic [ADDR_W-1:0]   sa;
	logic [FREE_W-1:0]   fs;

	assign st = m_tdata[STATUS_W-1:0];
	assign sa = m_tdata[OUT_ADDR_LSB +: ADDR_W];
	assign fs = m_tdata[OUT_FREE_LSB +: FREE_W];

	// one request at a time
	`DFLA_AST_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "request taken while busy")
	// only a good allocate carries an address
	`DFLA_AST_NOW(a_fail_no_addr, m_tvalid && (st != STAT_OK), sa == '0, "address on failed beat")
	// empty list means no free slots reported
	`DFLA_AST_NOW(a_empty_depth, m_tvalid && (st == STAT_EMPTY), fs == '0, "empty with free slots")
	`DFLA_AST_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result dropped")

endmodule

bind descriptor_free_list_allocator dfla_checker u_dfla_checker (.*);

>>> bench/descriptor_free_list_allocator_tb.sv
`timescale 1ns / 1ps
module descriptor_free_list_allocator_tb;
	import dfla_pkg::*;

	localparam int SLOTS         = DEF_MAX_SLOTS;
	localparam int RAND_PHASES   = 10;
	localparam int PHASE_ITEMS   = 75;
	localparam int SETTLE_CYCLES = 40;
	localparam int LONG_HOLD     = 300;
	localparam int LIMIT_NS      = 5_000_000;

	// code 3 is not an operation; the block answers it without touching the stack
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [ADDR_W-1:0]    slot_address;
		logic [IDX_OUT_W-1:0] slot_index;
		logic [FREE_W-1:0]    free_slots;
	} slot_result_t;

	typedef struct {
		bit                is_cfg;
		logic [1:0]        code;   // func, or register index on a write row
		logic [ADDR_W-1:0] value;  // free_address, or register data
		bit                typed;
		slot_result_t      want;
	} plan_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [ADDR_W-1:0]      cfg_data;

	descriptor_free_list_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// mirror of the allocator state
	logic [IDX_OUT_W-1:0] shadow_stack [SLOTS];
	logic [FREE_W-1:0]    shadow_depth;
	logic [ADDR_W-1:0]    shadow_base;
	logic [STRIDE_W-1:0]  shadow_stride;
	logic [CNT_W-1:0]     shadow_count;

	slot_result_t pending_results [$];
	plan_row_t    plan [$];
	logic [ADDR_W-1:0] held [$];

	int  mismatches;
	int  results_seen;
	int  requests_sent;
	int  cfg_writes;
	int  status_count [4];
	bit  steady;
	bit  stall_req;

	slot_result_t seen_beat;
	slot_result_t oldest;

	function automatic int unsigned active_slots();
		return (shadow_count > SLOTS) ? SLOTS : shadow_count;
	endfunction

	function automatic void refill_stack(input int unsigned n);
		for (int i = 0; i < SLOTS; i++)
			shadow_stack[i] = i[IDX_OUT_W-1:0];
		shadow_depth = n[FREE_W-1:0];
	endfunction

	function automatic logic [ADDR_W-1:0] rand_addr();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[ADDR_W-1:0];
	endfunction

	function automatic slot_result_t predict_slot_op(input logic [FUNC_W-1:0] f,
			input logic [ADDR_W-1:0] a);
		slot_result_t         r;
		int unsigned          cnt;
		longint unsigned      extent;
		longint unsigned      offset;
		longint unsigned      step;
		logic [IDX_OUT_W-1:0] idx;
		r = '0;
		cnt = active_slots();
		extent = cnt;
		extent = extent * shadow_stride;
		offset = a;
		offset = offset - shadow_base;
		case (f)
			FUNC_ALLOC: begin
				if (shadow_depth == 0 || shadow_depth > SLOTS) begin
					r.status = STAT_EMPTY;
				end else begin
					shadow_depth = shadow_depth - 1'b1;
					idx = shadow_stack[shadow_depth];
					step = idx;
					step = step * shadow_stride;
					// wraps modulo the address width
					r.slot_address = shadow_base + step[ADDR_W-1:0];
					r.slot_index = idx;
				end
			end
			FUNC_FREE: begin
				// range check wins over the full check
				if (shadow_stride == 0 || a < shadow_base || offset >= extent) begin
					r.status = STAT_RANGE;
				end else if (shadow_depth >= cnt) begin
					r.status = STAT_FULL;
				end else begin
					offset = offset / shadow_stride;
					idx = offset[IDX_OUT_W-1:0];
					shadow_stack[shadow_depth] = idx;
					shadow_depth = shadow_depth + 1'b1;
					r.slot_index = idx;
				end
			end
			FUNC_REINIT: refill_stack(cnt);
			default: ;
		endcase
		r.free_slots = shadow_depth;
		return r;
	endfunction

	function automatic void plan_cfg(input logic [CFG_IDX_W-1:0] idx,
			input logic [ADDR_W-1:0] value);
		plan_row_t row;
		row = '{1'b1, idx, value, 1'b0, '0};
		plan.push_back(row);
	endfunction

	function automatic void plan_item(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
			input bit typed, input logic [STATUS_W-1:0] st, input logic [ADDR_W-1:0] sa,
			input logic [IDX_OUT_W-1:0] si, input logic [FREE_W-1:0] fs);
		plan_row_t row;
		row = '{1'b0, f, a, typed, '{st, sa, si, fs}};
		plan.push_back(row);
	endfunction

	// offers one request beat, then records its expected result at the accepting edge
	task automatic push_request(input logic [FUNC_W-1:0] f, input logic [ADDR_W-1:0] a,
			input bit typed, input slot_result_t want, output slot_result_t got);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - IN_W){1'b0}}, a, f};
		do @(posedge clk); while (!s_tready);
		got = predict_slot_op(f, a);
		pending_results.push_back(typed ? want : got);
		requests_sent++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
		wait_drained();
		repeat (SETTLE_CYCLES / 2) @(posedge clk);
		cfg_index <= idx;
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_BASE:   shadow_base   = value;
			REG_STRIDE: shadow_stride = value[STRIDE_W-1:0];
			REG_COUNT:  shadow_count  = value[CNT_W-1:0];
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic note_mismatch(input string field, input longint unsigned want,
			input longint unsigned got);
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch in %s at result %0d: expected %h, got %h",
				field, results_seen, want, got);
	endtask

	// result side: per-beat random hold-off, plus one long stall on request
	initial begin : result_sink
		int w;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (stall_req) begin
				stall_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			w = steady ? 0 : $urandom_range(0, 4);
			if (w != 0) begin
				m_tready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_beat.status       = m_tdata[STATUS_W-1:0];
			seen_beat.slot_address = m_tdata[OUT_ADDR_LSB +: ADDR_W];
			seen_beat.slot_index   = m_tdata[OUT_IDX_LSB +: IDX_OUT_W];
			seen_beat.free_slots   = m_tdata[OUT_FREE_LSB +: FREE_W];
			status_count[seen_beat.status]++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat with nothing outstanding: %h", m_tdata);
			end else begin
				oldest = pending_results.pop_front();
				if (seen_beat.status != oldest.status)
					note_mismatch("status", oldest.status, seen_beat.status);
				if (seen_beat.slot_address != oldest.slot_address)
					note_mismatch("slot_address", oldest.slot_address, seen_beat.slot_address);
				if (seen_beat.slot_index != oldest.slot_index)
					note_mismatch("slot_index", oldest.slot_index, seen_beat.slot_index);
				if (seen_beat.free_slots != oldest.free_slots)
					note_mismatch("free_slots", oldest.free_slots, seen_beat.free_slots);
			end
			results_seen++;
		end
	end

	initial begin
		#(LIMIT_NS);
		$display("descriptor_free_list_allocator test failed");
		$finish;
	end

	initial begin
		slot_result_t      res;
		int                phase;
		int                k;
		int                pick;
		int                j;
		longint unsigned   extent;
		longint unsigned   offs;
		logic [FUNC_W-1:0] f;
		logic [ADDR_W-1:0] a;

		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_BASE;
		cfg_data  = '0;
		steady    = 1'b0;
		stall_req = 1'b0;
		mismatches    = 0;
		results_seen  = 0;
		requests_sent = 0;
		cfg_writes    = 0;
		foreach (status_count[i]) status_count[i] = 0;
		shadow_base   = RST_BASE;
		shadow_stride = RST_STRIDE;
		shadow_count  = RST_COUNT;
		refill_stack(RST_DEPTH_CAP);

		// reset values: base 0, stride 32, all 1024 slots free
		plan_item(FUNC_FREE,   48'd0,               1, STAT_FULL,  '0, '0, 11'd1024);
		plan_item(FUNC_ALLOC,  48'd0,               1, STAT_OK,    48'd32736, 10'd1023, 11'd1023);
		plan_item(FUNC_FREE,   48'd32768,           1, STAT_RANGE, '0, '0, 11'd1023);
		plan_item(FUNC_FREE,   48'hFFFF_FFFF_FFFF,  1, STAT_RANGE, '0, '0, 11'd1023);
		// inside the last slot: quotient truncates
		plan_item(FUNC_FREE,   48'd32767,           1, STAT_OK,    '0, 10'd1023, 11'd1024);
		plan_item(FUNC_UNUSED, 48'hFFFF_FFFF_FFFF,  1, STAT_OK,    '0, '0, 11'd1024);
		plan_item(FUNC_ALLOC,  48'd0,               0, '0, '0, '0, '0);
		// slot at base itself is inside the heap
		plan_item(FUNC_FREE,   48'd0,               1, STAT_OK,    '0, '0, 11'd1024);
		// top of the address space with the widest normal stride
		plan_cfg(REG_BASE,   48'hFFFF_FFFF_F000);
		plan_cfg(REG_STRIDE, 48'd4096);
		plan_item(FUNC_REINIT, 48'd0,               1, STAT_OK,    '0, '0, 11'd1024);
		plan_item(FUNC_ALLOC,  48'd0,               0, '0, '0, '0, '0);
		plan_item(FUNC_FREE,   48'hFFFF_FFFF_EFFF,  1, STAT_RANGE, '0, '0, 11'd1023);
		plan_item(FUNC_FREE,   48'hFFFF_FFFF_F000,  0, '0, '0, '0, '0);
		plan_item(FUNC_FREE,   48'hFFFF_FFFF_FFFF,  0, '0, '0, '0, '0);
		// zero stride and zero count: nothing is in the heap
		plan_cfg(REG_STRIDE, 48'd0);
		plan_item(FUNC_FREE,   48'hFFFF_FFFF_F000,  1, STAT_RANGE, '0, '0, 11'd1024);
		plan_cfg(REG_BASE,   48'd0);
		plan_cfg(REG_STRIDE, 48'd1);
		plan_cfg(REG_COUNT,  48'd0);
		plan_item(FUNC_FREE,   48'd0,               1, STAT_RANGE, '0, '0, 11'd1024);
		plan_item(FUNC_REINIT, 48'd0,               1, STAT_OK,    '0, '0, 11'd0);
		plan_item(FUNC_ALLOC,  48'd0,               1, STAT_EMPTY, '0, '0, 11'd0);
		// count above the slot limit, largest stride the register holds
		plan_cfg(REG_COUNT,  48'd2047);
		plan_cfg(REG_STRIDE, 48'd8191);
		plan_item(FUNC_REINIT, 48'd0,               1, STAT_OK,    '0, '0, 11'd1024);
		plan_item(FUNC_FREE,   48'd8387583,         0, '0, '0, '0, '0);
		plan_item(FUNC_FREE,   48'd8387584,         1, STAT_RANGE, '0, '0, 11'd1024);
		plan_item(FUNC_ALLOC,  48'd0,               0, '0, '0, '0, '0);
		plan_item(FUNC_FREE,   48'd8387583,         0, '0, '0, '0, '0);
		// single slot heap
		plan_cfg(REG_BASE,   48'd5);
		plan_cfg(REG_STRIDE, 48'd1);
		plan_cfg(REG_COUNT,  48'd1);
		plan_item(FUNC_REINIT, 48'd0,               1, STAT_OK,    '0, '0, 11'd1);
		plan_item(FUNC_ALLOC,  48'd0,               1, STAT_OK,    48'd5, '0, 11'd0);
		plan_item(FUNC_ALLOC,  48'd0,               1, STAT_EMPTY, '0, '0, 11'd0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_reg(plan[i].code, plan[i].value);
			else
				push_request(plan[i].code, plan[i].value, plan[i].typed, plan[i].want, res);
		end

		for (phase = 0; phase < RAND_PHASES; phase++) begin
			case (phase % 5)
				0: begin
					write_reg(REG_BASE, rand_addr());
					write_reg(REG_STRIDE, $urandom_range(1, 4096));
					write_reg(REG_COUNT, SLOTS);
				end
				1: begin
					write_reg(REG_BASE, rand_addr());
					write_reg(REG_STRIDE, $urandom_range(1, 8));
					write_reg(REG_COUNT, $urandom_range(1, 16));
				end
				2: begin
					write_reg(REG_BASE, 48'hFFFF_FFFF_FFFF - $urandom_range(0, 65535));
					write_reg(REG_STRIDE, 48'd4096);
					write_reg(REG_COUNT, $urandom_range(SLOTS + 1, 2047));
				end
				3: begin
					write_reg(REG_BASE, rand_addr());
					write_reg(REG_STRIDE, $urandom_range(1, 8191));
					write_reg(REG_COUNT, $urandom_range(1, 64));
				end
				default: begin
					// lower the count but keep whatever indices the stack holds
					write_reg(REG_COUNT, $urandom_range(1, 8));
				end
			endcase
			if (phase % 5 != 4) begin
				push_request(FUNC_REINIT, rand_addr(), 1'b0, '0, res);
				held.delete();
			end
			steady = (phase == 3);
			if (phase == 1)
				stall_req = 1'b1;

			for (k = 0; k < PHASE_ITEMS; k++) begin
				if (phase == 6 && k == PHASE_ITEMS / 2)
					wait_drained();
				extent = active_slots();
				extent = extent * shadow_stride;
				pick = $urandom_range(0, 99);
				f = FUNC_FREE;
				a = rand_addr();
				if (pick < 40 || (pick < 75 && held.size() == 0)) begin
					f = FUNC_ALLOC;
				end else if (pick < 75) begin
					// hand back a slot we hold, anywhere inside it
					j = $urandom_range(0, held.size() - 1);
					a = held[j] + ((shadow_stride > 1) ? $urandom_range(0, shadow_stride - 1) : 0);
					held.delete(j);
				end else if (pick < 83) begin
					offs = (extent != 0) ? ($urandom % extent) : 0;
					a = shadow_base + offs[ADDR_W-1:0];
				end else if (pick < 90) begin
					a = rand_addr();
				end else if (pick < 94) begin
					a = $urandom_range(0, 1) ? shadow_base - 1'b1 : shadow_base + extent[ADDR_W-1:0];
				end else if (pick < 97) begin
					f = FUNC_UNUSED;
				end else begin
					f = FUNC_REINIT;
					held.delete();
				end
				push_request(f, a, 1'b0, '0, res);
				if (f == FUNC_ALLOC && res.status == STAT_OK)
					held.push_back(res.slot_address);
			end
			steady = 1'b0;
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("%0d requests over %0d register writes, %0d results checked", requests_sent,
			cfg_writes, results_seen);
		$display("status seen: ok %0d, empty %0d, outside heap %0d, full %0d; mismatches %0d",
			status_count[STAT_OK], status_count[STAT_EMPTY], status_count[STAT_RANGE],
			status_count[STAT_FULL], mismatches);
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("descriptor_free_list_allocator test passed");
		end else begin
			$display("descriptor_free_list_allocator test failed");
		end
		$finish;
	end

endmodule

>>> descriptor_free_list_allocator.f
+incdir+hw/rtl
hw/rtl/dfla_pkg.sv
hw/rtl/dfla_ram.sv
hw/rtl/descriptor_free_list_allocator.sv
hw/rtl/dfla_checker.sv
bench/descriptor_free_list_allocator_tb.sv
